/* src/fctrp_pkg.sv */
// Shared types and constants for the FM chip timer and register port.
// Used by fctrp_timers, fctrp_out_queue and fm_chip_timer_register_port_core.
`default_nettype none

package fctrp_pkg;

  // Parameter defaults
  localparam int SLOW_TIMER_DIV_DEF    = 4;
  localparam int CHANNELS_PER_BANK_DEF = 9;

  // Item opcodes
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // Bus ports
  localparam logic [1:0] PORT_ADDR0 = 2'd0;
  localparam logic [1:0] PORT_ADDR1 = 2'd2;

  // Configuration register indexes
  localparam logic CFG_FOUR_OP_VARIANT = 1'b0;
  localparam logic CFG_TIMERS_PRESENT  = 1'b1;

  // Chip register indexes and values
  localparam logic [7:0] REG_PRESET_ONE = 8'h02;
  localparam logic [7:0] REG_PRESET_TWO = 8'h03;
  localparam logic [7:0] REG_TIMER_CTRL = 8'h04;
  localparam logic [7:0] REG_BANK_SEL   = 8'h05;
  localparam logic [8:0] REG_FOUR_OP    = 9'h105;
  localparam logic [7:0] REG_KEY_ON     = 8'hB0;

  localparam logic [7:0] STATUS_ANY     = 8'h80;
  localparam logic [7:0] STATUS_T1      = 8'h40;
  localparam logic [7:0] STATUS_T2      = 8'h20;
  localparam logic [7:0] STATUS_OPL2    = 8'h06;
  localparam logic [7:0] READ_OPL2_DATA = 8'hFF;

  typedef struct packed {
    logic       tick;
    logic       wr_preset_one;
    logic       wr_preset_two;
    logic       wr_ctrl;
    logic [7:0] data;
  } timer_cmd_t;

  typedef struct packed {
    logic [1:0] ovf;      // current flags, bit0 T1, bit1 T2
    logic       irq_nxt;  // IRQ line after the current command
  } timer_status_t;

  // read_data in the lowest bits
  typedef struct packed {
    logic       all_silent;
    logic [7:0] fwd_data;
    logic [8:0] fwd_index;
    logic       fwd_valid;
    logic       irq_level;
    logic [7:0] read_data;
  } result_t;

endpackage

`default_nettype wire

/* src/fctrp_timers.sv */
// Two 8-bit up-count timers with preset reload, mask, start and flag reset.
// Depends on fctrp_pkg for the command and status structs.
`default_nettype none

module fctrp_timers #(
  parameter int SLOW_TIMER_DIV = fctrp_pkg::SLOW_TIMER_DIV_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire fctrp_pkg::timer_cmd_t    cmd,
  output fctrp_pkg::timer_status_t      status
);

  localparam int PRE_W = (SLOW_TIMER_DIV > 1) ? $clog2(SLOW_TIMER_DIV) : 1;
  localparam logic [PRE_W:0] DIV_C = (PRE_W + 1)'(SLOW_TIMER_DIV);

  logic [7:0]       preset_one_r, preset_one_nxt;
  logic [7:0]       preset_two_r, preset_two_nxt;
  logic [7:0]       count_one_r, count_one_nxt;
  logic [7:0]       count_two_r, count_two_nxt;
  logic [PRE_W-1:0] prescale_r, prescale_nxt;
  logic [1:0]       run_r, run_nxt;
  logic [1:0]       mask_r, mask_nxt;
  logic [1:0]       ovf_r, ovf_nxt;
  logic             irq_r, irq_nxt;
  logic [PRE_W:0]   pre_inc;

  always_comb begin
    preset_one_nxt = preset_one_r;
    preset_two_nxt = preset_two_r;
    count_one_nxt  = count_one_r;
    count_two_nxt  = count_two_r;
    prescale_nxt   = prescale_r;
    run_nxt        = run_r;
    mask_nxt       = mask_r;
    ovf_nxt        = ovf_r;
    irq_nxt        = irq_r;
    pre_inc        = {1'b0, prescale_r} + (PRE_W + 1)'(1);

    if (cmd.tick) begin
      if (run_r[0]) begin
        count_one_nxt = count_one_r + 8'd1;
        if (count_one_nxt == 8'd0) begin
          count_one_nxt = preset_one_r;
          if (!mask_r[0] && !ovf_r[0]) begin
            ovf_nxt[0] = 1'b1;
            irq_nxt    = 1'b1;
          end
        end
      end
      if (run_r[1]) begin
        if (pre_inc >= DIV_C) begin
          prescale_nxt  = '0;
          count_two_nxt = count_two_r + 8'd1;
          if (count_two_nxt == 8'd0) begin
            count_two_nxt = preset_two_r;
            if (!mask_r[1] && !ovf_r[1]) begin
              ovf_nxt[1] = 1'b1;
              irq_nxt    = 1'b1;
            end
          end
        end else begin
          prescale_nxt = pre_inc[PRE_W-1:0];
        end
      end
    end

    if (cmd.wr_preset_one) preset_one_nxt = cmd.data;
    if (cmd.wr_preset_two) preset_two_nxt = cmd.data;
    if (cmd.wr_ctrl) begin
      if (cmd.data[7]) begin
        // flag reset: nothing else in the byte takes effect
        ovf_nxt = 2'b00;
        irq_nxt = 1'b0;
      end else begin
        mask_nxt = {cmd.data[5], cmd.data[6]};
        run_nxt  = cmd.data[1:0];
        if (cmd.data[0]) count_one_nxt = preset_one_r;
        if (cmd.data[1]) begin
          count_two_nxt = preset_two_r;
          prescale_nxt  = '0;
        end
        ovf_nxt = ovf_r & ~mask_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      preset_one_r <= '0;
      preset_two_r <= '0;
      count_one_r  <= '0;
      count_two_r  <= '0;
      prescale_r   <= '0;
      run_r        <= '0;
      mask_r       <= '0;
      ovf_r        <= '0;
      irq_r        <= 1'b0;
    end else begin
      preset_one_r <= preset_one_nxt;
      preset_two_r <= preset_two_nxt;
      count_one_r  <= count_one_nxt;
      count_two_r  <= count_two_nxt;
      prescale_r   <= prescale_nxt;
      run_r        <= run_nxt;
      mask_r       <= mask_nxt;
      ovf_r        <= ovf_nxt;
      irq_r        <= irq_nxt;
    end
  end

  assign status.ovf     = ovf_r;
  assign status.irq_nxt = irq_nxt;

  // a masked timer never holds its flag
  a_mask_clears_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (ovf_r & mask_r) == 2'b00)
    else $error("masked timer holds overflow flag");

  // IRQ only rises together with a newly set flag
  a_irq_rise_flag: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(irq_r) |-> (ovf_r != 2'b00))
    else $error("IRQ raised without overflow flag");

  a_prescale_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, prescale_r} < DIV_C)
    else $error("prescaler out of range");

endmodule

`default_nettype wire

/* src/fctrp_out_queue.sv */
// Two-entry result queue between the register port logic and the out channel.
// Depends on fctrp_pkg for the result struct.
`default_nettype none

module fctrp_out_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push_valid,
  output logic                    push_ready,
  input  wire fctrp_pkg::result_t push_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output fctrp_pkg::result_t      out_data
);

  fctrp_pkg::result_t entry_r [2];
  logic [1:0]         count_r, count_nxt;
  logic               wr_ptr_r, rd_ptr_r;
  logic               push, pop;

  assign push_ready = (count_r != 2'd2);
  assign out_valid  = (count_r != 2'd0);
  assign push       = push_valid && push_ready;
  assign pop        = out_valid && out_ready;
  assign out_data   = entry_r[rd_ptr_r];

  always_comb begin
    case ({push, pop})
      2'b10:   count_nxt = count_r + 2'd1;
      2'b01:   count_nxt = count_r - 2'd1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_data;
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("result queue count overflow");

  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd0 || count_r == 2'd2) |-> (wr_ptr_r == rd_ptr_r))
    else $error("result queue pointers out of step");

  a_last_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push && count_r == 2'd1) |=> !out_valid)
    else $error("result queue not empty after last pop");

endmodule

`default_nettype wire

/* src/fm_chip_timer_register_port_core.sv */
// Top level of the FM chip host register port: address latch, forwarding, key-on
// tracking and status reads. Depends on fctrp_pkg, fctrp_timers, fctrp_out_queue.
//
// Usage:
//   in_*  : one transaction per bus read, bus write or 80 us base tick.
//           in_tdata = {bus_data, port, opcode}, opcode in the lowest bits.
//   out_* : exactly one result per input transaction, in order.
//   cfg_* : register writes (0 four_op_variant, 1 timers_present); always ready,
//           to be written only while the block is idle; the block does not check it.
// Output: the result of an item is registered into the output queue on acceptance.
// Throughput: one item per cycle while in_tready is high; all state updates for
// an item happen in the accepting cycle, the result lands in a two-entry output queue.
// Stall: while out_tready is low the queue holds up to two results, and in_tready
// drops only when both entries are full; it rises again once a pop is registered.
// Reset (rst_n low, synchronous): timers stopped and unmasked, flags and IRQ
// clear, address latch and key-on bits zero, queue empty, four_op_variant 0,
// timers_present 1.
`default_nettype none

module fm_chip_timer_register_port_core #(
  parameter int SLOW_TIMER_DIV    = fctrp_pkg::SLOW_TIMER_DIV_DEF,
  parameter int CHANNELS_PER_BANK = fctrp_pkg::CHANNELS_PER_BANK_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [1:0] opcode, [3:2] port, [11:4] bus_data, [15:12] zero
  input  wire logic [15:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [7:0] read_data, [8] irq_level, [9] fwd_valid, [18:10] fwd_index,
  // [26:19] fwd_data, [27] all_silent, [31:28] zero
  output logic [31:0]      out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic        cfg_data
);

  localparam int KEYS  = 2 * CHANNELS_PER_BANK;
  localparam int KEY_W = (KEYS > 1) ? $clog2(KEYS) : 1;
  localparam logic [7:0] KEY_END = fctrp_pkg::REG_KEY_ON + 8'(CHANNELS_PER_BANK);

  logic [1:0] op;
  logic [1:0] port;
  logic [7:0] bus_data;
  logic       accept;

  logic            four_op_variant_r, timers_present_r;
  logic [8:0]      addr_latch_r, addr_latch_nxt;
  logic            four_op_mode_r, four_op_mode_nxt;
  logic [KEYS-1:0] key_on_r, key_on_nxt;

  logic       is_addr_port, data_wr, key_hit;
  logic [7:0] lo, key_off, status_byte;
  logic [KEY_W-1:0] key_idx;

  fctrp_pkg::timer_cmd_t    tcmd;
  fctrp_pkg::timer_status_t tstat;
  fctrp_pkg::result_t       res;
  fctrp_pkg::result_t       q_data;

  assign op       = in_tdata[1:0];
  assign port     = in_tdata[3:2];
  assign bus_data = in_tdata[11:4];
  assign accept   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign is_addr_port = (port == fctrp_pkg::PORT_ADDR0) || (port == fctrp_pkg::PORT_ADDR1);
  assign data_wr      = accept && (op == fctrp_pkg::OP_WRITE) && !is_addr_port;
  assign lo           = addr_latch_r[7:0];
  assign key_hit      = (lo >= fctrp_pkg::REG_KEY_ON) && (lo < KEY_END);
  assign key_off      = lo - fctrp_pkg::REG_KEY_ON;
  assign key_idx      = key_off[KEY_W-1:0] +
                        (addr_latch_r[8] ? KEY_W'(CHANNELS_PER_BANK) : KEY_W'(0));

  always_comb begin
    addr_latch_nxt   = addr_latch_r;
    four_op_mode_nxt = four_op_mode_r;
    key_on_nxt       = key_on_r;
    if (accept && (op == fctrp_pkg::OP_WRITE) && is_addr_port) begin
      addr_latch_nxt = {1'b0, bus_data};
      if (four_op_variant_r && (port == fctrp_pkg::PORT_ADDR1) &&
          (four_op_mode_r || bus_data == fctrp_pkg::REG_BANK_SEL))
        addr_latch_nxt[8] = 1'b1;
    end
    if (data_wr) begin
      if (addr_latch_r == fctrp_pkg::REG_FOUR_OP) four_op_mode_nxt = bus_data[0];
      if (key_hit) key_on_nxt[key_idx] = bus_data[5];
    end
  end

  // timer commands: register writes from bank 0 only, and only with timers installed; ticks always pass
  always_comb begin
    tcmd.tick          = accept && (op == fctrp_pkg::OP_TICK);
    tcmd.wr_preset_one = data_wr && timers_present_r && !addr_latch_r[8] &&
                         (lo == fctrp_pkg::REG_PRESET_ONE);
    tcmd.wr_preset_two = data_wr && timers_present_r && !addr_latch_r[8] &&
                         (lo == fctrp_pkg::REG_PRESET_TWO);
    tcmd.wr_ctrl       = data_wr && timers_present_r && !addr_latch_r[8] &&
                         (lo == fctrp_pkg::REG_TIMER_CTRL);
    tcmd.data          = bus_data;
  end

  fctrp_timers #(
    .SLOW_TIMER_DIV(SLOW_TIMER_DIV)
  ) u_timers (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (tcmd),
    .status(tstat)
  );

  always_comb begin
    status_byte = (tstat.ovf[0] ? fctrp_pkg::STATUS_T1 : 8'h00) |
                  (tstat.ovf[1] ? fctrp_pkg::STATUS_T2 : 8'h00);
    if (tstat.ovf != 2'b00) status_byte = status_byte | fctrp_pkg::STATUS_ANY;

    res.read_data = 8'h00;
    if (op == fctrp_pkg::OP_READ) begin
      if (four_op_variant_r)
        res.read_data = (port == fctrp_pkg::PORT_ADDR0) ? status_byte : 8'h00;
      else
        res.read_data = (port == fctrp_pkg::PORT_ADDR0) ?
                        (status_byte | fctrp_pkg::STATUS_OPL2) : fctrp_pkg::READ_OPL2_DATA;
    end
    res.irq_level  = tstat.irq_nxt;
    res.fwd_valid  = (op == fctrp_pkg::OP_WRITE) && !is_addr_port;
    res.fwd_index  = res.fwd_valid ? addr_latch_r : 9'd0;
    res.fwd_data   = res.fwd_valid ? bus_data : 8'd0;
    res.all_silent = (key_on_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      four_op_variant_r <= 1'b0;
      timers_present_r  <= 1'b1;
      addr_latch_r      <= '0;
      four_op_mode_r    <= 1'b0;
      key_on_r          <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          fctrp_pkg::CFG_FOUR_OP_VARIANT: four_op_variant_r <= cfg_data;
          fctrp_pkg::CFG_TIMERS_PRESENT:  timers_present_r  <= cfg_data;
          default: ;
        endcase
      end
      addr_latch_r   <= addr_latch_nxt;
      four_op_mode_r <= four_op_mode_nxt;
      key_on_r       <= key_on_nxt;
    end
  end

  fctrp_out_queue u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(in_tvalid),
    .push_ready(in_tready),
    .push_data (res),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (q_data)
  );

  assign out_tdata = {4'b0000, q_data};

  // bit 8 of the latch is only set on the four-operator chip
  a_bank_variant: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(addr_latch_r[8]) |-> $past(four_op_variant_r))
    else $error("bank bit set on the two-operator chip");

  // a flag reset drops the IRQ in the same transaction
  a_flag_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (tcmd.wr_ctrl && bus_data[7]) |-> !tstat.irq_nxt)
    else $error("IRQ still high after flag reset");

  // a stalled result holds steady
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result changed while stalled");

endmodule

`default_nettype wire
